// ----- rtl/core/u2h_pkg.sv -----
// ----------------------------------------------------------------------------
// u2h_pkg
// Shared types, key usage ids and lookup functions for the UTF-8 to HID
// keystroke sequencer.
// ----------------------------------------------------------------------------
package u2h_pkg;

	localparam logic [7:0] KEY_LSHIFT = 8'hE1;
	localparam logic [7:0] KEY_LALT   = 8'hE2;
	localparam logic [7:0] KEY_EQUAL  = 8'h2E;
	localparam logic [7:0] KEY_NONE   = 8'h00;

	localparam logic [3:0] ALT_LAST_STEP   = 4'd13;
	localparam logic [3:0] SHIFT_LAST_STEP = 4'd3;
	localparam logic [3:0] PLAIN_LAST_STEP = 4'd1;

	// one finished character, handed from the decoder to the sequencer
	typedef struct packed {
		logic        alt;
		logic        shift;
		logic [7:0]  key;
		logic [15:0] code_point;
	} job_t;

	typedef struct packed {
		logic       shift;
		logic [7:0] key;
	} key_map_t;

	typedef struct packed {
		logic [7:0] usage;
		logic       down;
		logic       chg;
		logic       rep;
		logic       last;
	} result_t;

	function automatic key_map_t map_key(input logic [7:0] ch);
		key_map_t m;
		m.shift = 1'b0;
		m.key   = KEY_NONE;
		if (ch == 8'h30) begin
			m.key = 8'h27;
		end else if (ch >= 8'h31 && ch <= 8'h39) begin
			m.key = ch - 8'h13;
		end else if (ch >= 8'h41 && ch <= 8'h5A) begin
			m.shift = 1'b1;
			m.key   = ch - 8'h3D;
		end else if (ch >= 8'h61 && ch <= 8'h7A) begin
			m.key = ch - 8'h5D;
		end else begin
			case (ch)
				8'h08: m.key = 8'h2A;
				8'h09: m.key = 8'h2B;
				8'h0A: m.key = 8'h28;
				8'h0D: m.key = 8'h28;
				8'h1B: m.key = 8'h29;
				8'h20: m.key = 8'h2C;
				8'h21: begin m.shift = 1'b1; m.key = 8'h1E; end
				8'h22: begin m.shift = 1'b1; m.key = 8'h34; end
				8'h23: begin m.shift = 1'b1; m.key = 8'h20; end
				8'h24: begin m.shift = 1'b1; m.key = 8'h21; end
				8'h25: begin m.shift = 1'b1; m.key = 8'h22; end
				8'h26: begin m.shift = 1'b1; m.key = 8'h24; end
				8'h27: m.key = 8'h34;
				8'h28: begin m.shift = 1'b1; m.key = 8'h26; end
				8'h29: begin m.shift = 1'b1; m.key = 8'h27; end
				8'h2A: begin m.shift = 1'b1; m.key = 8'h25; end
				8'h2B: begin m.shift = 1'b1; m.key = 8'h2E; end
				8'h2C: m.key = 8'h36;
				8'h2D: m.key = 8'h2D;
				8'h2E: m.key = 8'h37;
				8'h2F: m.key = 8'h38;
				8'h3A: begin m.shift = 1'b1; m.key = 8'h33; end
				8'h3B: m.key = 8'h33;
				8'h3C: begin m.shift = 1'b1; m.key = 8'h36; end
				8'h3D: m.key = 8'h2E;
				8'h3E: begin m.shift = 1'b1; m.key = 8'h37; end
				8'h3F: begin m.shift = 1'b1; m.key = 8'h38; end
				8'h40: begin m.shift = 1'b1; m.key = 8'h1F; end
				8'h5B: m.key = 8'h2F;
				8'h5C: m.key = 8'h31;
				8'h5D: m.key = 8'h30;
				8'h5E: begin m.shift = 1'b1; m.key = 8'h23; end
				8'h5F: begin m.shift = 1'b1; m.key = 8'h2D; end
				8'h60: m.key = 8'h35;
				8'h7B: begin m.shift = 1'b1; m.key = 8'h2F; end
				8'h7C: begin m.shift = 1'b1; m.key = 8'h31; end
				8'h7D: begin m.shift = 1'b1; m.key = 8'h30; end
				8'h7E: begin m.shift = 1'b1; m.key = 8'h35; end
				8'h7F: m.key = 8'h4C;
				default: m.key = KEY_NONE;
			endcase
		end
		return m;
	endfunction

	function automatic logic [7:0] hex_key(input logic [3:0] nib);
		logic [7:0] k;
		if (nib == 4'd0) begin
			k = 8'h27;
		end else if (nib < 4'd10) begin
			k = 8'h1D + {4'b0, nib};
		end else begin
			k = {4'b0, nib} - 8'd6;
		end
		return k;
	endfunction

endpackage

// ----- rtl/core/u2h_front.sv -----
// ----------------------------------------------------------------------------
// u2h_front
// UTF-8 decoder: gathers code point bits, drops four-byte characters and
// stray bytes, and classifies each finished character as a mapped key or an
// Alt-code sequence.
// ----------------------------------------------------------------------------
module u2h_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [7:0]     text_byte,
	input  logic           accept,
	output logic           job_push,
	output u2h_pkg::job_t  job
);
	import u2h_pkg::*;

	logic [1:0]  expected_q;
	logic        skipping_q;
	logic [15:0] cp_q;

	logic [1:0]  expected_d;
	logic        skipping_d;
	logic [15:0] cp_d;
	logic        done;
	key_map_t    km;
	logic        hit;

	always_comb begin
		expected_d = expected_q;
		skipping_d = skipping_q;
		cp_d       = cp_q;
		done       = 1'b0;
		if (expected_q != 2'd0) begin
			expected_d = expected_q - 2'd1;
			if (skipping_q) begin
				if (expected_d == 2'd0) skipping_d = 1'b0;
			end else begin
				cp_d = {cp_q[9:0], text_byte[5:0]};
				done = (expected_d == 2'd0);
			end
		end else begin
			skipping_d = 1'b0;
			priority if (text_byte == 8'h00) begin
				// terminator outside a character: drop
			end else if (!text_byte[7]) begin
				cp_d = {8'h00, text_byte};
				done = 1'b1;
			end else if (text_byte[7:5] == 3'b110) begin
				cp_d       = {11'b0, text_byte[4:0]};
				expected_d = 2'd1;
			end else if (text_byte[7:4] == 4'b1110) begin
				cp_d       = {12'b0, text_byte[3:0]};
				expected_d = 2'd2;
			end else if (text_byte[7:3] == 5'b11110) begin
				skipping_d = 1'b1;
				expected_d = 2'd3;
			end else begin
				// stray continuation or invalid lead: drop
			end
		end
	end

	always_comb begin
		km             = map_key(text_byte);
		hit            = (cp_d == {8'h00, text_byte}) && (km.key != KEY_NONE);
		job.alt        = !hit;
		job.shift      = hit && km.shift;
		job.key        = km.key;
		job.code_point = cp_d;
		job_push       = accept && done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_q <= 2'd0;
			skipping_q <= 1'b0;
			cp_q       <= 16'h0000;
		end else if (accept) begin
			expected_q <= expected_d;
			skipping_q <= skipping_d;
			cp_q       <= cp_d;
		end
	end

endmodule

// ----- rtl/core/u2h_queue.sv -----
// ----------------------------------------------------------------------------
// u2h_queue
// Two-entry queue of decoded characters between the decoder and the
// keystroke sequencer.
// ----------------------------------------------------------------------------
module u2h_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  u2h_pkg::job_t  push_job,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output u2h_pkg::job_t  head_job
);
	import u2h_pkg::*;

	localparam int unsigned Depth = 2;

	job_t       mem_q [Depth];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] count_q;

	assign full       = (count_q == 2'(Depth));
	assign head_valid = (count_q != 2'd0);
	assign head_job   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- rtl/core/u2h_back.sv -----
// ----------------------------------------------------------------------------
// u2h_back
// Keystroke sequencer: steps through the key changes of the character at the
// head of the queue, one result per cycle unless stalled, into the output register.
// ----------------------------------------------------------------------------
module u2h_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_valid,
	input  u2h_pkg::job_t  job,
	output logic           job_pop,
	output logic [7:0]     usage_code,
	output logic           key_down,
	output logic           changes_key,
	output logic           send_report,
	output logic           run_end,
	output logic           out_valid,
	input  logic           out_ready
);
	import u2h_pkg::*;

	logic [3:0] step_q;
	logic       out_valid_q;
	result_t    res_q;

	logic [3:0] last_step;
	logic       advance;
	result_t    res;
	logic [7:0] hi_a;
	logic [7:0] hi_b;
	logic [7:0] lo_a;
	logic [7:0] lo_b;

	always_comb begin
		hi_a = hex_key(job.code_point[15:12]);
		hi_b = hex_key(job.code_point[11:8]);
		lo_a = hex_key(job.code_point[7:4]);
		lo_b = hex_key(job.code_point[3:0]);
		if (job.alt) begin
			last_step = ALT_LAST_STEP;
		end else if (job.shift) begin
			last_step = SHIFT_LAST_STEP;
		end else begin
			last_step = PLAIN_LAST_STEP;
		end
	end

	always_comb begin
		res      = '{usage: KEY_NONE, down: 1'b0, chg: 1'b1, rep: 1'b1, last: 1'b0};
		res.last = (step_q == last_step);
		if (job.alt) begin
			unique case (step_q)
				4'd0:  begin res.usage = KEY_LALT;  res.down = 1'b1; end
				4'd1:  begin res.usage = KEY_EQUAL; res.down = 1'b1; end
				4'd2:  res.usage = KEY_EQUAL;
				4'd3:  begin res.usage = hi_a; res.down = 1'b1; end
				4'd4:  res.usage = hi_a;
				4'd5:  begin res.usage = hi_b; res.down = 1'b1; end
				4'd6:  res.usage = hi_b;
				4'd7:  res.chg = 1'b0;
				4'd8:  begin res.usage = lo_a; res.down = 1'b1; end
				4'd9:  res.usage = lo_a;
				4'd10: begin res.usage = lo_b; res.down = 1'b1; end
				4'd11: res.usage = lo_b;
				4'd12: res.chg = 1'b0;
				default: res.usage = KEY_LALT;
			endcase
		end else if (job.shift) begin
			// shift changes go out without their own report
			unique case (step_q)
				4'd0:    begin res.usage = KEY_LSHIFT; res.down = 1'b1; res.rep = 1'b0; end
				4'd1:    begin res.usage = job.key; res.down = 1'b1; end
				4'd2:    begin res.usage = KEY_LSHIFT; res.rep = 1'b0; end
				default: res.usage = job.key;
			endcase
		end else begin
			res.usage = job.key;
			res.down  = (step_q == 4'd0);
		end
	end

	assign advance = job_valid && (!out_valid_q || out_ready);
	assign job_pop = advance && res.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= 4'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				step_q <= res.last ? 4'd0 : step_q + 4'd1;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) res_q <= res;
	end

	assign usage_code  = res_q.usage;
	assign key_down    = res_q.down;
	assign changes_key = res_q.chg;
	assign send_report = res_q.rep;
	assign run_end     = res_q.last;
	assign out_valid   = out_valid_q;

endmodule

// ----- rtl/core/utf8_text_to_hid_keystrokes.sv -----
// ----------------------------------------------------------------------------
// utf8_text_to_hid_keystrokes
// Decodes UTF-8 text bytes and types each character as HID key changes:
// a mapped key (2 or 4 results) or a Left Alt hex code (14 results).
// ----------------------------------------------------------------------------
// After the last byte of a character is accepted, the character is written to
// the queue and its first result then to the output register.
// Throughput: one byte per cycle while the two-entry character queue has room;
// the sequencer emits one result per cycle while the receiver keeps up.
// Reset: arst_n clears decoder state, queue pointers and output valid.
module utf8_text_to_hid_keystrokes (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] text_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] usage_code,
	output logic       key_down,
	output logic       changes_key,
	output logic       send_report,
	output logic       run_end
);
	import u2h_pkg::*;

	logic accept;
	logic push;
	job_t push_job;
	logic full;
	logic pop;
	logic head_valid;
	job_t head_job;

	assign in_ready = !full;
	assign accept   = in_valid && in_ready;

	u2h_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.text_byte (text_byte),
		.accept    (accept),
		.job_push  (push),
		.job       (push_job)
	);

	u2h_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	u2h_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.job_valid   (head_valid),
		.job         (head_job),
		.job_pop     (pop),
		.usage_code  (usage_code),
		.key_down    (key_down),
		.changes_key (changes_key),
		.send_report (send_report),
		.run_end     (run_end),
		.out_valid   (out_valid),
		.out_ready   (out_ready)
	);

endmodule

// ----- tb/utf8_text_to_hid_keystrokes_tb.sv -----
// ----------------------------------------------------------------------------
// utf8_text_to_hid_keystrokes_tb
// Feeds UTF-8 text through the keystroke sequencer with bursty input and a
// stalling receiver. Every accepted byte is decoded by a local predictor into
// the key changes it should type, and each result is checked against them.
// ----------------------------------------------------------------------------
module utf8_text_to_hid_keystrokes_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import u2h_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int TEXT_ITEMS  = 350;
	localparam int LONG_HOLD   = 400;
	localparam logic [6:0] READY_PATTERN = 7'b1011001;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] text_byte = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] usage_code;
	logic       key_down;
	logic       changes_key;
	logic       send_report;
	logic       run_end;

	// predictor state
	logic [1:0]  cont_left;
	logic        dropping;
	logic [15:0] code_acc;

	logic [7:0] text_q [$];
	result_t    keystroke_q [$];

	int burst_left = 0;
	int gap_left = 0;
	int hold_left = 0;
	bit held_once = 1'b0;
	int rx_cycle = 0;
	int cycle_count = 0;
	int mismatches = 0;
	int bytes_sent = 0;
	int results_checked = 0;
	int plain_chars = 0;
	int shifted_chars = 0;
	int alt_chars = 0;
	int text_count;
	int noise_len;

	utf8_text_to_hid_keystrokes DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.text_byte   (text_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.usage_code  (usage_code),
		.key_down    (key_down),
		.changes_key (changes_key),
		.send_report (send_report),
		.run_end     (run_end)
	);

	always #10 clk = ~clk;

	// returns {shift, usage}; usage zero means no key for this character
	function automatic logic [8:0] ascii_key(input logic [7:0] ch);
		logic [8:0] r;
		r = 9'h000;
		if (ch == 8'h30) begin
			r = {1'b0, 8'h27};
		end else if (ch >= 8'h31 && ch <= 8'h39) begin
			r = {1'b0, 8'h1E + (ch - 8'h31)};
		end else if (ch >= 8'h41 && ch <= 8'h5A) begin
			r = {1'b1, 8'h04 + (ch - 8'h41)};
		end else if (ch >= 8'h61 && ch <= 8'h7A) begin
			r = {1'b0, 8'h04 + (ch - 8'h61)};
		end else begin
			case (ch)
				8'h08: r = {1'b0, 8'h2A};
				8'h09: r = {1'b0, 8'h2B};
				8'h0A, 8'h0D: r = {1'b0, 8'h28};
				8'h1B: r = {1'b0, 8'h29};
				8'h20: r = {1'b0, 8'h2C};
				8'h21: r = {1'b1, 8'h1E};
				8'h22: r = {1'b1, 8'h34};
				8'h23: r = {1'b1, 8'h20};
				8'h24: r = {1'b1, 8'h21};
				8'h25: r = {1'b1, 8'h22};
				8'h26: r = {1'b1, 8'h24};
				8'h27: r = {1'b0, 8'h34};
				8'h28: r = {1'b1, 8'h26};
				8'h29: r = {1'b1, 8'h27};
				8'h2A: r = {1'b1, 8'h25};
				8'h2B: r = {1'b1, 8'h2E};
				8'h2C: r = {1'b0, 8'h36};
				8'h2D: r = {1'b0, 8'h2D};
				8'h2E: r = {1'b0, 8'h37};
				8'h2F: r = {1'b0, 8'h38};
				8'h3A: r = {1'b1, 8'h33};
				8'h3B: r = {1'b0, 8'h33};
				8'h3C: r = {1'b1, 8'h36};
				8'h3D: r = {1'b0, 8'h2E};
				8'h3E: r = {1'b1, 8'h37};
				8'h3F: r = {1'b1, 8'h38};
				8'h40: r = {1'b1, 8'h1F};
				8'h5B: r = {1'b0, 8'h2F};
				8'h5C: r = {1'b0, 8'h31};
				8'h5D: r = {1'b0, 8'h30};
				8'h5E: r = {1'b1, 8'h23};
				8'h5F: r = {1'b1, 8'h2D};
				8'h60: r = {1'b0, 8'h35};
				8'h7B: r = {1'b1, 8'h2F};
				8'h7C: r = {1'b1, 8'h31};
				8'h7D: r = {1'b1, 8'h30};
				8'h7E: r = {1'b1, 8'h35};
				8'h7F: r = {1'b0, 8'h4C};
				default: r = 9'h000;
			endcase
		end
		return r;
	endfunction

	function automatic logic [7:0] digit_usage(input logic [3:0] nib);
		if (nib == 4'd0)
			return 8'h27;
		else if (nib < 4'd10)
			return 8'h1D + {4'b0, nib};
		else
			return 8'h04 + {4'b0, nib} - 8'd10;
	endfunction

	function automatic result_t key_event(input logic [7:0] usage, input logic down,
			input logic chg, input logic rep);
		result_t e;
		e.usage = usage;
		e.down  = down;
		e.chg   = chg;
		e.rep   = rep;
		e.last  = 1'b0;
		return e;
	endfunction

	task automatic type_character(input logic [7:0] last_byte, input logic [15:0] cp);
		result_t    seq [0:13];
		int         n;
		logic [8:0] km;
		logic [7:0] v;
		logic [7:0] hi;
		logic [7:0] lo;
		n  = 0;
		km = ascii_key(last_byte);
		if ({8'h00, last_byte} == cp && km[7:0] != KEY_NONE) begin
			if (km[8]) begin
				seq[n++] = key_event(KEY_LSHIFT, 1'b1, 1'b1, 1'b0);
				seq[n++] = key_event(km[7:0], 1'b1, 1'b1, 1'b1);
				seq[n++] = key_event(KEY_LSHIFT, 1'b0, 1'b1, 1'b0);
				seq[n++] = key_event(km[7:0], 1'b0, 1'b1, 1'b1);
				shifted_chars++;
			end else begin
				seq[n++] = key_event(km[7:0], 1'b1, 1'b1, 1'b1);
				seq[n++] = key_event(km[7:0], 1'b0, 1'b1, 1'b1);
				plain_chars++;
			end
		end else begin
			seq[n++] = key_event(KEY_LALT, 1'b1, 1'b1, 1'b1);
			seq[n++] = key_event(KEY_EQUAL, 1'b1, 1'b1, 1'b1);
			seq[n++] = key_event(KEY_EQUAL, 1'b0, 1'b1, 1'b1);
			for (int k = 0; k < 2; k++) begin
				v  = (k == 0) ? cp[15:8] : cp[7:0];
				hi = digit_usage(v[7:4]);
				lo = digit_usage(v[3:0]);
				seq[n++] = key_event(hi, 1'b1, 1'b1, 1'b1);
				seq[n++] = key_event(hi, 1'b0, 1'b1, 1'b1);
				seq[n++] = key_event(lo, 1'b1, 1'b1, 1'b1);
				seq[n++] = key_event(lo, 1'b0, 1'b1, 1'b1);
				seq[n++] = key_event(KEY_NONE, 1'b0, 1'b0, 1'b1);
			end
			seq[n++] = key_event(KEY_LALT, 1'b0, 1'b1, 1'b1);
			alt_chars++;
		end
		seq[n-1].last = 1'b1;
		for (int i = 0; i < n; i++)
			keystroke_q.push_back(seq[i]);
	endtask

	task automatic decode_text_byte(input logic [7:0] b);
		if (cont_left != 2'd0) begin
			cont_left = cont_left - 2'd1;
			if (dropping) begin
				if (cont_left == 2'd0)
					dropping = 1'b0;
			end else begin
				code_acc = {code_acc[9:0], b[5:0]};
				if (cont_left == 2'd0)
					type_character(b, code_acc);
			end
		end else begin
			dropping = 1'b0;
			if (b == 8'h00) begin
				// terminator outside a character: drop
			end else if (b[7] == 1'b0) begin
				code_acc = {8'h00, b};
				type_character(b, code_acc);
			end else if (b[7:5] == 3'b110) begin
				code_acc  = {11'h000, b[4:0]};
				cont_left = 2'd1;
			end else if (b[7:4] == 4'b1110) begin
				code_acc  = {12'h000, b[3:0]};
				cont_left = 2'd2;
			end else if (b[7:3] == 5'b11110) begin
				dropping  = 1'b1;
				cont_left = 2'd3;
			end
		end
	endtask

	task automatic check_keystroke();
		result_t exp_r;
		if (keystroke_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result: usage=%02h down=%0b chg=%0b rep=%0b end=%0b",
					usage_code, key_down, changes_key, send_report, run_end);
		end else begin
			exp_r = keystroke_q.pop_front();
			if (usage_code !== exp_r.usage || key_down !== exp_r.down ||
					changes_key !== exp_r.chg || send_report !== exp_r.rep ||
					run_end !== exp_r.last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d mismatch: exp usage=%02h down=%0b chg=%0b rep=%0b end=%0b, got usage=%02h down=%0b chg=%0b rep=%0b end=%0b",
						results_checked, exp_r.usage, exp_r.down, exp_r.chg, exp_r.rep,
						exp_r.last, usage_code, key_down, changes_key, send_report,
						run_end);
			end
		end
		results_checked++;
	endtask

	// sender: bursts of requests separated by random gaps
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid   <= 1'b0;
			text_byte  <= 8'h00;
			cont_left  = 2'd0;
			dropping   = 1'b0;
			code_acc   = 16'h0000;
			burst_left = $urandom_range(1, 20);
			gap_left   = 0;
		end else begin
			if (in_valid && in_ready) begin
				decode_text_byte(text_byte);
				bytes_sent++;
			end
			if (in_valid && !in_ready) begin
				// hold the request until accepted
			end else if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (text_q.size() != 0) begin
				in_valid  <= 1'b1;
				text_byte <= text_q.pop_front();
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 24);
					case ($urandom_range(0, 7))
						0, 1, 2: gap_left = 0;
						7:       gap_left = $urandom_range(10, 40);
						default: gap_left = $urandom_range(1, 6);
					endcase
				end else begin
					burst_left--;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: cycles through stall patterns, with one long hold-off
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready)
				check_keystroke();
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (!held_once && results_checked >= 60) begin
				held_once = 1'b1;
				hold_left = LONG_HOLD;
				out_ready <= 1'b0;
			end else begin
				case ((rx_cycle / 89) % 4)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(0, 3) != 0);
					2: out_ready <= READY_PATTERN[3'(rx_cycle % 7)];
					default: out_ready <= 1'($urandom_range(0, 1));
				endcase
			end
			rx_cycle++;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, keystroke_q.size());
			$display("utf8_text_to_hid_keystrokes_tb: FAIL");
			$finish;
		end
	end

	task automatic add_cont_byte();
		text_q.push_back(8'h80 | 8'($urandom_range(0, 63)));
	endtask

	initial begin
		// plain, shifted, '@', a digit, delete, strays, multi-byte and skipped chars
		text_q = '{8'h00, 8'h61, 8'h5A, 8'h40, 8'h30, 8'h7F, 8'h80, 8'hFF, 8'hF8,
			8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'hF0, 8'h9F, 8'h98, 8'h80,
			8'hC1, 8'h41, 8'hC0, 8'h00, 8'hE0, 8'h01, 8'h41};
		text_count = text_q.size();
		while (text_count < TEXT_ITEMS) begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5, 6, 7, 8, 9: begin
					text_q.push_back(8'($urandom_range(1, 127)));
					text_count++;
				end
				10, 11, 12, 13: begin
					text_q.push_back(8'hC0 | 8'($urandom_range(0, 31)));
					add_cont_byte();
					text_count += 2;
				end
				14, 15, 16: begin
					text_q.push_back(8'hE0 | 8'($urandom_range(0, 15)));
					add_cont_byte();
					add_cont_byte();
					text_count += 3;
				end
				17: begin
					text_q.push_back(8'hF0 | 8'($urandom_range(0, 7)));
					repeat (3) text_q.push_back(8'($urandom_range(0, 255)));
					text_count += 4;
				end
				default: begin
					// noise: any byte, including broken and truncated sequences
					noise_len = int'($urandom_range(1, 3));
					repeat (noise_len) text_q.push_back(8'($urandom_range(0, 255)));
					text_count += noise_len;
				end
			endcase
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (text_q.size() != 0 || in_valid)
			@(posedge clk);
		while (keystroke_q.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		if (keystroke_q.size() != 0) begin
			mismatches += keystroke_q.size();
			$display("%0d expected results never arrived", keystroke_q.size());
		end
		$display("sent %0d text bytes, checked %0d key results", bytes_sent, results_checked);
		$display("typed %0d plain, %0d shifted and %0d alt-code characters",
			plain_chars, shifted_chars, alt_chars);
		if (mismatches == 0) begin
			$display("utf8_text_to_hid_keystrokes_tb: PASS");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("utf8_text_to_hid_keystrokes_tb: FAIL");
		end
		$finish;
	end

endmodule
